>>> rtl/core/rau_pkg.sv
// shared types and constants for the rational arithmetic unit
`timescale 1ns / 1ps
package rau_pkg;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    localparam int DATA_W = 64;
    localparam int IN_W   = 32;
    localparam int QUEUE_DEPTH = 2;

    // classified word handed from front to back
    typedef struct packed {
        op_t              op;
        logic [IN_W-1:0]  a_num;
        logic [IN_W-1:0]  a_den;
        logic [IN_W-1:0]  b_num;
        logic [IN_W-1:0]  b_den;
        logic             zero_den;
    } work_t;

    typedef struct packed {
        logic [DATA_W-1:0] result_num;
        logic [62:0]       result_den;
        logic              status;
    } result_t;

endpackage

>>> rtl/core/rau_front.sv
// front end: accepts words, flags zero denominators, and queues them
`timescale 1ns / 1ps
module rau_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  rau_pkg::op_t     in_op,
    input  logic [31:0]      in_a_num,
    input  logic [31:0]      in_a_den,
    input  logic [31:0]      in_b_num,
    input  logic [31:0]      in_b_den,
    output logic             q_valid,
    input  logic             q_ready,
    output rau_pkg::work_t   q_data
);
    import rau_pkg::*;

    work_t            mem_reg [QUEUE_DEPTH];
    logic             wr_ptr_reg, rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             push, pop;
    work_t            item;

    // d is zero exactly when one of its two factors is zero
    always_comb begin
        item.op    = in_op;
        item.a_num = in_a_num;
        item.a_den = in_a_den;
        item.b_num = in_b_num;
        item.b_den = in_b_den;
        item.zero_den = (in_a_den == '0) ||
                        ((in_op == OP_DIV) ? (in_b_num == '0) : (in_b_den == '0));
    end

    assign in_ready = (count_reg != 2'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != 2'd0);
    assign q_data   = mem_reg[rd_ptr_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'(QUEUE_DEPTH)) else $error("queue overflow");
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == 2'(QUEUE_DEPTH)) |-> !push) else $error("push while full");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("count mismatch");

endmodule

>>> rtl/core/rau_divider.sv
// shared unsigned 64-bit restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
module rau_divider (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  dividend,
    input  logic [63:0]  divisor,
    output logic         done,
    output logic [63:0]  quotient,
    output logic [63:0]  remainder
);
    import rau_pkg::*;

    logic [63:0] quot_reg, rem_reg, dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic [64:0] trial;
    logic [64:0] shifted;

    assign shifted   = {rem_reg, quot_reg[63]};
    assign trial     = shifted - {1'b0, dsr_reg};
    assign done      = done_reg;
    assign quotient  = quot_reg;
    assign remainder = rem_reg;

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= dividend;
            rem_reg  <= '0;
            dsr_reg  <= divisor;
        end else if (busy_reg) begin
            if (!trial[64]) begin
                rem_reg  <= trial[63:0];
                quot_reg <= {quot_reg[62:0], 1'b1};
            end else begin
                rem_reg  <= shifted[63:0];
                quot_reg <= {quot_reg[62:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

endmodule

>>> rtl/core/rau_back.sv
// back end: products, euclid gcd, reduction and sign fix-up
`timescale 1ns / 1ps
module rau_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  rau_pkg::work_t   q_data,
    output logic             out_valid,
    input  logic             out_ready,
    output rau_pkg::result_t out_data
);
    import rau_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_SUM, S_GCD_START, S_GCD_RUN, S_GCD_WAIT,
        S_DIVN_START, S_DIVN_WAIT, S_DIVD_START, S_DIVD_WAIT, S_OUT
    } state_t;

    state_t       state_reg;
    work_t        item_reg;
    logic [63:0]  p1_reg, p2_reg, d_reg, n_reg;
    logic [63:0]  x_reg, y_reg, rn_reg;
    logic         neg_reg;
    result_t      res_reg;

    logic         div_start, div_done;
    logic [63:0]  div_a, div_b, div_q, div_r;
    logic signed [31:0] m1a, m1b, m2a, m2b;
    logic signed [63:0] prod1, prod2;
    logic [63:0]  nm, dm;

    rau_divider u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .dividend(div_a), .divisor(div_b), .done(div_done),
        .quotient(div_q), .remainder(div_r)
    );

    // two 32x32 multipliers: S_MUL1 forms the n terms, S_MUL2 forms d
    always_comb begin
        m1a = item_reg.a_num;
        m1b = (item_reg.op == OP_MUL) ? item_reg.b_num : item_reg.b_den;
        m2a = item_reg.b_num;
        m2b = item_reg.a_den;
        if (state_reg == S_MUL2) begin
            m1a = item_reg.a_den;
            m1b = (item_reg.op == OP_DIV) ? item_reg.b_num : item_reg.b_den;
        end
        prod1 = m1a * m1b;
        prod2 = m2a * m2b;
    end

    assign nm = n_reg[63] ? (64'd0 - n_reg) : n_reg;
    assign dm = d_reg[63] ? (64'd0 - d_reg) : d_reg;

    // euclid steps use x mod y; the final quotients divide by the gcd held in x
    always_comb begin
        div_start = 1'b0;
        div_a     = x_reg;
        div_b     = y_reg;
        unique case (state_reg)
            S_GCD_RUN:    div_start = (y_reg != '0);
            S_DIVN_START: begin
                div_start = 1'b1;
                div_a     = nm;
                div_b     = x_reg;
            end
            S_DIVD_START: begin
                div_start = 1'b1;
                div_a     = dm;
                div_b     = x_reg;
            end
            default: ;
        endcase
    end

    assign q_ready   = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_data  = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (q_valid) begin
                        item_reg  <= q_data;
                        res_reg   <= '{result_num: '0, result_den: '0, status: 1'b1};
                        state_reg <= q_data.zero_den ? S_OUT : S_MUL1;
                    end
                end
                S_MUL1: begin
                    p1_reg <= 64'(prod1);
                    p2_reg <= 64'(prod2);
                    state_reg <= S_MUL2;
                end
                S_MUL2: begin
                    d_reg <= 64'(prod1);
                    state_reg <= S_SUM;
                end
                S_SUM: begin
                    unique case (item_reg.op)
                        OP_ADD:  n_reg <= p1_reg + p2_reg;
                        OP_SUB:  n_reg <= p1_reg - p2_reg;
                        default: n_reg <= p1_reg;
                    endcase
                    state_reg <= S_GCD_START;
                end
                S_GCD_START: begin
                    neg_reg   <= n_reg[63] ^ d_reg[63];
                    x_reg     <= nm;
                    y_reg     <= dm;
                    state_reg <= S_GCD_RUN;
                end
                S_GCD_RUN: begin
                    // remainder reached zero: gcd sits in x
                    state_reg <= (y_reg == '0) ? S_DIVN_START : S_GCD_WAIT;
                end
                S_GCD_WAIT: begin
                    if (div_done) begin
                        x_reg     <= y_reg;
                        y_reg     <= div_r;
                        state_reg <= S_GCD_RUN;
                    end
                end
                S_DIVN_START: begin
                    state_reg <= S_DIVN_WAIT;
                end
                S_DIVN_WAIT: begin
                    if (div_done) begin
                        rn_reg    <= div_q;
                        state_reg <= S_DIVD_START;
                    end
                end
                S_DIVD_START: begin
                    state_reg <= S_DIVD_WAIT;
                end
                S_DIVD_WAIT: begin
                    if (div_done) begin
                        res_reg.status <= 1'b0;
                        if (rn_reg == '0) begin
                            res_reg.result_num <= '0;
                            res_reg.result_den <= 63'd1;
                        end else begin
                            res_reg.result_num <= neg_reg ? (64'd0 - rn_reg) : rn_reg;
                            res_reg.result_den <= div_q[62:0];
                        end
                        state_reg <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_ready) |=> out_valid) else $error("result dropped");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && out_data.status) |-> (out_data.result_den == '0))
        else $error("error result has nonzero denominator");
    a_ok_den: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid && !out_data.status) |-> (out_data.result_den != '0))
        else $error("ok result with zero denominator");

endmodule

>>> rtl/core/rational_arith_unit_core.sv
// top level of the rational arithmetic unit
`timescale 1ns / 1ps
// Adds, subtracts, multiplies or divides two signed 32-bit fractions and returns the
// result reduced by its gcd with a positive denominator; a zero numerator gives 0/1 and a
// zero denominator gives 0/0 with status set. A two-entry queue decouples the input from
// the arithmetic back end, which handles one word at a time: it takes the word from the
// queue, forms the products and setup, then runs each Euclid remainder step through
// the shared bit-serial 64-bit divider (at least one step, up to about 92 steps on 64-bit
// magnitudes), closes the gcd and computes the two final quotients before the result is
// offered. Zero-denominator words are offered the cycle after they leave the queue. The
// next word enters the back end only after the current result is taken.
module rational_arith_unit_core (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [1:0]    s_tuser,   // operation
    input  logic [127:0]  s_tdata,   // a_num, a_den, b_num, b_den
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [127:0]  m_tdata,   // result_num, result_den, zero pad
    output logic          m_tuser    // status
);
    import rau_pkg::*;

    logic    q_valid, q_ready;
    work_t   q_data;
    result_t res;

    rau_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .in_op(op_t'(s_tuser)),
        .in_a_num(s_tdata[31:0]), .in_a_den(s_tdata[63:32]),
        .in_b_num(s_tdata[95:64]), .in_b_den(s_tdata[127:96]),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    rau_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_data(res)
    );

    assign m_tdata = {1'b0, res.result_den, res.result_num};
    assign m_tuser = res.status;

endmodule

>>> tb/rational_arith_unit_core_tb.sv
// self-checking testbench for the rational arithmetic unit core
`timescale 1ns / 1ps
module rational_arith_unit_core_tb;
    import rau_pkg::*;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [1:0]   s_tuser;   // operation
    logic [127:0] s_tdata;   // a_num, a_den, b_num, b_den
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;   // result_num, result_den, zero pad
    logic         m_tuser;   // status

    localparam logic [31:0] MAX_POS = 32'h7fff_ffff;
    localparam logic [31:0] MAX_NEG = 32'h8000_0001;
    localparam logic [31:0] MIN_INT = 32'h8000_0000;

    result_t     quotient_q[$];
    int          error_count;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned recv_hold_cycles;

    rational_arith_unit_core uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // reduced fraction of the two operands under the given operation
    function automatic result_t reduce_fraction(op_t op, logic [31:0] an32, logic [31:0] ad32,
                                                logic [31:0] bn32, logic [31:0] bd32);
        logic [63:0] an, ad, bn, bd, n, d, nm, dm, x, y, r, rn, rd;
        logic        neg;
        result_t     res;
        an = {{32{an32[31]}}, an32};
        ad = {{32{ad32[31]}}, ad32};
        bn = {{32{bn32[31]}}, bn32};
        bd = {{32{bd32[31]}}, bd32};
        case (op)
            OP_ADD: begin
                n = an * bd + bn * ad;
                d = ad * bd;
            end
            OP_SUB: begin
                n = an * bd - bn * ad;
                d = ad * bd;
            end
            OP_MUL: begin
                n = an * bn;
                d = ad * bd;
            end
            default: begin
                n = an * bd;
                d = ad * bn;
            end
        endcase
        if (d == 64'd0) begin
            res.result_num = '0;
            res.result_den = '0;
            res.status = 1'b1;
            return res;
        end
        nm = n[63] ? -n : n;
        dm = d[63] ? -d : d;
        x = nm;
        y = dm;
        while (y != 64'd0) begin
            r = x % y;
            x = y;
            y = r;
        end
        rn = nm / x;
        rd = dm / x;
        neg = (n[63] ^ d[63]) && (rn != 64'd0);
        if (rn == 64'd0)
            rd = 64'd1;
        res.result_num = neg ? -rn : rn;
        res.result_den = rd[62:0];
        res.status = 1'b0;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic send_word(op_t op, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {bd, bn, ad, an};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        quotient_q.push_back(reduce_fraction(op, an, ad, bn, bd));
    endtask

    function automatic logic [31:0] pick_operand();
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 72)
            return 32'($signed($urandom_range(2000)) - 1000);
        else if (sel < 84)
            case ($urandom_range(5))
                0: return 32'd0;
                1: return 32'd1;
                2: return 32'hffff_ffff;
                3: return MAX_POS;
                4: return MAX_NEG;
                default: return MIN_INT;
            endcase
        return $urandom;
    endfunction

    task automatic send_random_word();
        send_word(op_t'($urandom_range(3)), pick_operand(), pick_operand(),
                  pick_operand(), pick_operand());
    endtask

    // receiver: random stalls, or a counted long hold
    always @(posedge aclk) begin
        if (recv_hold_cycles != 0) begin
            m_tready <= 1'b0;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (quotient_q.size() == 0) begin
                report_mismatch("unexpected word", m_tdata[63:0], 64'd0);
            end else begin
                result_t want;
                want = quotient_q.pop_front();
                if (m_tdata[63:0] !== want.result_num)
                    report_mismatch("result_num", m_tdata[63:0], want.result_num);
                if (m_tdata[126:64] !== want.result_den)
                    report_mismatch("result_den", {1'b0, m_tdata[126:64]},
                                    {1'b0, want.result_den});
                if (m_tuser !== want.status)
                    report_mismatch("status", {63'd0, m_tuser}, {63'd0, want.status});
            end
        end
    end

    task automatic test_directed();
        send_word(OP_ADD, 32'd1, 32'd2, 32'd1, 32'd3);
        send_word(OP_SUB, 32'd1, 32'd2, 32'd1, 32'd2);          // zero numerator
        send_word(OP_MUL, 32'hffff_fffd, 32'd4, 32'd2, 32'hffff_fffa);
        send_word(OP_DIV, 32'd3, 32'd5, 32'hffff_fff9, 32'd2);
        send_word(OP_DIV, 32'd3, 32'd5, 32'd0, 32'd2);          // divide by zero
        send_word(OP_ADD, 32'd1, 32'd0, 32'd1, 32'd1);          // zero a_den
        send_word(OP_MUL, 32'd1, 32'd1, 32'd1, 32'd0);          // zero b_den
        send_word(OP_MUL, MAX_POS, MAX_POS, MAX_POS, MAX_POS);
        send_word(OP_ADD, MAX_POS, 32'd1, MAX_POS, 32'd1);
        send_word(OP_SUB, MAX_NEG, MAX_POS, MAX_POS, MAX_NEG);
        send_word(OP_DIV, MAX_NEG, 32'd3, MAX_POS, MAX_NEG);
        send_word(OP_MUL, 32'd0, MAX_NEG, 32'd5, 32'd7);
        // numerator wraps to -2^63
        send_word(OP_ADD, MIN_INT, MIN_INT, MIN_INT, MIN_INT);
        send_word(OP_SUB, MIN_INT, 32'd1, MAX_POS, 32'd1);
        send_word(OP_DIV, MIN_INT, 32'd1, MIN_INT, 32'hffff_ffff);
        send_word(OP_ADD, 32'h0001_0000, 32'h0003_0000, 32'h0002_0000, 32'h0005_0000);
    endtask

    task automatic test_random(int count, int unsigned s_pct, int unsigned r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (count)
            send_random_word();
    endtask

    // hold the receiver while words keep coming so the input stalls
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 9000;
        repeat (8)
            send_random_word();
    endtask

    task automatic test_drain_pause();
        repeat (4) begin
            send_random_word();
            s_tvalid <= 1'b0;
            wait (quotient_q.size() == 0);
            @(posedge aclk);
        end
    endtask

    initial begin
        error_count = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tuser = OP_ADD;
        s_tdata = '0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random(600, 23, 78);
        test_backpressure();
        test_random(600, 78, 23);
        test_drain_pause();
        test_random(600, 0, 0);

        s_tvalid <= 1'b0;
        wait (quotient_q.size() == 0);
        repeat (200) @(posedge aclk);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #400ms;
        $display("FAILURE");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/rau_pkg.sv
rtl/core/rau_front.sv
rtl/core/rau_divider.sv
rtl/core/rau_back.sv
rtl/core/rational_arith_unit_core.sv
tb/rational_arith_unit_core_tb.sv
